// ===== design/owm_pkg.sv =====
package owm_pkg;

    // configuration register width and bus widths
    localparam int CFG_W     = 10;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;

    // reset values of the timing registers, in ticks
    localparam logic [CFG_W-1:0] RST_RESET_LOW      = 10'd480;
    localparam logic [CFG_W-1:0] RST_PRESENCE_WAIT  = 10'd80;
    localparam logic [CFG_W-1:0] RST_PRESENCE_TAIL  = 10'd400;
    localparam logic [CFG_W-1:0] RST_WRITE_ONE_LOW  = 10'd1;
    localparam logic [CFG_W-1:0] RST_WRITE_ZERO_LOW = 10'd60;
    localparam logic [CFG_W-1:0] RST_SLOT_RELEASE   = 10'd60;
    localparam logic [CFG_W-1:0] RST_READ_LOW       = 10'd2;
    localparam logic [CFG_W-1:0] RST_WRITE_ZERO_GAP = 10'd1;

    typedef enum logic [2:0] {
        REG_RESET_LOW      = 3'd0,
        REG_PRESENCE_WAIT  = 3'd1,
        REG_PRESENCE_TAIL  = 3'd2,
        REG_WRITE_ONE_LOW  = 3'd3,
        REG_WRITE_ZERO_LOW = 3'd4,
        REG_SLOT_RELEASE   = 3'd5,
        REG_READ_LOW       = 3'd6,
        REG_WRITE_ZERO_GAP = 3'd7
    } reg_idx_t;

    // command codes; code 3 means nothing and is ignored
    typedef enum logic [1:0] {
        FUNC_RESET = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_READ  = 2'd2
    } func_t;

    typedef struct packed {
        logic [CFG_W-1:0] reset_low;
        logic [CFG_W-1:0] presence_wait;
        logic [CFG_W-1:0] presence_tail;
        logic [CFG_W-1:0] write_one_low;
        logic [CFG_W-1:0] write_zero_low;
        logic [CFG_W-1:0] slot_release;
        logic [CFG_W-1:0] read_low;
        logic [CFG_W-1:0] write_zero_gap;
    } cfg_t;

    typedef struct packed {
        logic       bus_level;
        logic       cmd_valid;
        logic [1:0] func;
        logic [7:0] cmd_data;
    } item_t;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_data;
        logic       no_presence;
    } res_t;

endpackage

// ===== design/owm_apb_regs.sv =====
module owm_apb_regs
    import owm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output cfg_t              cfg
);

    cfg_t             cfg_reg;
    cfg_t             cfg_next;
    reg_idx_t         idx;
    logic [CFG_W-1:0] wval;
    logic [CFG_W-1:0] rval;

    assign idx    = reg_idx_t'(paddr[4:2]);
    assign wval   = pwdata[CFG_W-1:0];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_RESET_LOW:      cfg_next.reset_low      = wval;
                REG_PRESENCE_WAIT:  cfg_next.presence_wait  = wval;
                REG_PRESENCE_TAIL:  cfg_next.presence_tail  = wval;
                REG_WRITE_ONE_LOW:  cfg_next.write_one_low  = wval;
                REG_WRITE_ZERO_LOW: cfg_next.write_zero_low = wval;
                REG_SLOT_RELEASE:   cfg_next.slot_release   = wval;
                REG_READ_LOW:       cfg_next.read_low       = wval;
                REG_WRITE_ZERO_GAP: cfg_next.write_zero_gap = wval;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_RESET_LOW:      rval = cfg_reg.reset_low;
            REG_PRESENCE_WAIT:  rval = cfg_reg.presence_wait;
            REG_PRESENCE_TAIL:  rval = cfg_reg.presence_tail;
            REG_WRITE_ONE_LOW:  rval = cfg_reg.write_one_low;
            REG_WRITE_ZERO_LOW: rval = cfg_reg.write_zero_low;
            REG_SLOT_RELEASE:   rval = cfg_reg.slot_release;
            REG_READ_LOW:       rval = cfg_reg.read_low;
            REG_WRITE_ZERO_GAP: rval = cfg_reg.write_zero_gap;
            default:            rval = '0;
        endcase
    end

    assign prdata = APB_DW'(rval);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_low      <= RST_RESET_LOW;
            cfg_reg.presence_wait  <= RST_PRESENCE_WAIT;
            cfg_reg.presence_tail  <= RST_PRESENCE_TAIL;
            cfg_reg.write_one_low  <= RST_WRITE_ONE_LOW;
            cfg_reg.write_zero_low <= RST_WRITE_ZERO_LOW;
            cfg_reg.slot_release   <= RST_SLOT_RELEASE;
            cfg_reg.read_low       <= RST_READ_LOW;
            cfg_reg.write_zero_gap <= RST_WRITE_ZERO_GAP;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== design/owm_core.sv =====
module owm_core
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  step,
    input  item_t item,
    input  cfg_t  cfg,
    output res_t  res
);

    localparam int WB = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
    localparam logic [WB-1:0] TMAX = WB'((1 << TIMER_BITS) - 1);

    typedef enum logic [3:0] {
        PH_IDLE     = 4'd0,
        PH_RST_LOW  = 4'd1,
        PH_RST_WAIT = 4'd2,
        PH_RST_TAIL = 4'd3,
        PH_W1_LOW   = 4'd4,
        PH_W1_REL   = 4'd5,
        PH_W0_LOW   = 4'd6,
        PH_W0_GAP   = 4'd7,
        PH_R_LOW    = 4'd8,
        PH_R_REL    = 4'd9
    } phase_t;

    typedef struct packed {
        phase_t                ph;
        logic [TIMER_BITS-1:0] cd;
    } slot_t;

    phase_t                phase_reg,  phase_next;
    logic [TIMER_BITS-1:0] cd_reg,     cd_next;
    logic [2:0]            bit_reg,    bit_next;
    logic [7:0]            shift_reg,  shift_next;
    logic                  absent_reg, absent_next;
    func_t                 cmd_reg,    cmd_next;
    logic [7:0]            last_reg,   last_next;
    logic                  due_reg,    due_next;
    logic                  drive;
    logic                  fin;
    logic                  ended;
    logic [TIMER_BITS-1:0] cd_dec;
    logic [TIMER_BITS-1:0] tail_len;
    slot_t                 slot;

    // phase length: clipped to the timer, zero read as one unless allowed
    function automatic logic [TIMER_BITS-1:0] phase_len(input logic [CFG_W-1:0] v,
                                                        input logic zero_ok);
        logic [WB-1:0]         ext;
        logic [TIMER_BITS-1:0] r;
        ext = WB'(v);
        if (ext > TMAX)
            ext = TMAX;
        r = TIMER_BITS'(ext);
        if (r == '0 && !zero_ok)
            r = TIMER_BITS'(1);
        return r;
    endfunction

    // first phase of a bit slot
    function automatic slot_t start_slot(input func_t c, input logic [7:0] sh,
                                         input logic [2:0] bi, input cfg_t cf);
        slot_t s;
        if (c == FUNC_WRITE)
        begin
            if (sh[bi])
            begin
                s.ph = PH_W1_LOW;
                s.cd = phase_len(cf.write_one_low, 1'b0);
            end
            else
            begin
                s.ph = PH_W0_LOW;
                s.cd = phase_len(cf.write_zero_low, 1'b0);
            end
        end
        else
        begin
            s.ph = PH_R_LOW;
            s.cd = phase_len(cf.read_low, 1'b0);
        end
        return s;
    endfunction

    always_comb
    begin
        phase_next  = phase_reg;
        cd_next     = cd_reg;
        bit_next    = bit_reg;
        shift_next  = shift_reg;
        absent_next = absent_reg;
        cmd_next    = cmd_reg;
        last_next   = last_reg;
        due_next    = due_reg;
        drive       = 1'b0;
        fin         = 1'b0;
        slot        = '0;
        tail_len    = phase_len(cfg.presence_tail, 1'b1);

        // command start; the accepting tick is the first tick of the first phase
        if (phase_reg == PH_IDLE && item.cmd_valid && item.func <= FUNC_READ)
        begin
            cmd_next = func_t'(item.func);
            bit_next = 3'd0;
            due_next = 1'b0;
            if (func_t'(item.func) == FUNC_RESET)
            begin
                phase_next = PH_RST_LOW;
                cd_next    = phase_len(cfg.reset_low, 1'b0);
            end
            else
            begin
                shift_next = (func_t'(item.func) == FUNC_WRITE) ? item.cmd_data : 8'd0;
                slot       = start_slot(cmd_next, shift_next, 3'd0, cfg);
                phase_next = slot.ph;
                cd_next    = slot.cd;
            end
        end

        cd_dec = (cd_next != '0) ? cd_next - TIMER_BITS'(1) : cd_next;
        ended  = (cd_dec == '0);

        unique case (phase_next)
            PH_IDLE:
            begin
                phase_next = PH_IDLE;
            end
            PH_RST_LOW:
            begin
                drive   = 1'b1;
                cd_next = cd_dec;
                if (ended)
                begin
                    phase_next = PH_RST_WAIT;
                    cd_next    = phase_len(cfg.presence_wait, 1'b0);
                end
            end
            PH_RST_WAIT:
            begin
                cd_next = cd_dec;
                if (ended)
                begin
                    absent_next = item.bus_level;
                    if (tail_len == '0)
                        fin = 1'b1;
                    else
                    begin
                        phase_next = PH_RST_TAIL;
                        cd_next    = tail_len;
                    end
                end
            end
            PH_RST_TAIL:
            begin
                cd_next = cd_dec;
                fin     = ended;
            end
            PH_W1_LOW:
            begin
                drive   = 1'b1;
                cd_next = cd_dec;
                if (ended)
                begin
                    phase_next = PH_W1_REL;
                    cd_next    = phase_len(cfg.slot_release, 1'b0);
                end
            end
            PH_W0_LOW:
            begin
                drive   = 1'b1;
                cd_next = cd_dec;
                if (ended)
                begin
                    phase_next = PH_W0_GAP;
                    cd_next    = phase_len(cfg.write_zero_gap, 1'b0);
                end
            end
            PH_W1_REL, PH_W0_GAP, PH_R_REL:
            begin
                if (phase_next == PH_R_REL && due_next)
                begin
                    if (item.bus_level)
                        shift_next[bit_next] = 1'b1;
                    due_next = 1'b0;
                end
                cd_next = cd_dec;
                if (ended)
                begin
                    if (bit_next == 3'd7)
                        fin = 1'b1;
                    else
                    begin
                        bit_next   = bit_next + 3'd1;
                        slot       = start_slot(cmd_next, shift_next, bit_next, cfg);
                        phase_next = slot.ph;
                        cd_next    = slot.cd;
                    end
                end
            end
            PH_R_LOW:
            begin
                drive   = 1'b1;
                cd_next = cd_dec;
                if (ended)
                begin
                    phase_next = PH_R_REL;
                    cd_next    = phase_len(cfg.slot_release, 1'b0);
                    due_next   = 1'b1;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        if (fin)
        begin
            phase_next = PH_IDLE;
            cd_next    = '0;
            if (cmd_next == FUNC_READ)
                last_next = shift_next;
        end

        res.drive_low   = drive;
        res.busy_res    = (phase_next != PH_IDLE);
        res.done_res    = fin;
        res.read_data   = last_next;
        res.no_presence = absent_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            cd_reg     <= '0;
            bit_reg    <= 3'd0;
            shift_reg  <= 8'd0;
            absent_reg <= 1'b0;
            cmd_reg    <= FUNC_RESET;
            last_reg   <= 8'd0;
            due_reg    <= 1'b0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            cd_reg     <= cd_next;
            bit_reg    <= bit_next;
            shift_reg  <= shift_next;
            absent_reg <= absent_next;
            cmd_reg    <= cmd_next;
            last_reg   <= last_next;
            due_reg    <= due_next;
        end
    end

    // any active phase has ticks left to run
    a_cd_live: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg != PH_IDLE |-> cd_reg != '0)
        else $error("active phase with empty countdown");

    // a valid command taken while idle always leaves the block busy
    a_cmd_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (step && phase_reg == PH_IDLE && item.cmd_valid && item.func <= FUNC_READ)
            |=> phase_reg != PH_IDLE)
        else $error("command accepted but master stayed idle");

    // the read sample is only pending inside a read release phase
    a_due_phase: assert property (@(posedge clk) disable iff (!rst_n)
        due_reg |-> phase_reg == PH_R_REL)
        else $error("read sample pending outside read release");

endmodule

// ===== design/onewire_bus_master_unit.sv =====
// 1-Wire bus master, one stream item per microsecond tick.
// Input stream: each item carries the sampled line level and, optionally, a
//   command (reset with presence detect, write byte, read byte; LSB first).
//   Commands offered while a command runs, and func code 3, are ignored.
// Output stream: exactly one item per input item: drive_low for the line
//   driver, busy, a one-item done pulse, the last read byte and no-presence.
// Timing registers sit on the APB port (eight 10-bit registers, byte
//   address 4*index); write them only while the master is idle.
// Pipeline: an accepted item waits in the input register, is processed when
//   the result register can take it and is offered on m_tvalid from there.
// Throughput: one item per cycle while the result is not held by m_tready;
//   the whole tick (phase countdown, slot sequencing, sampling) is one pass
//   of logic between the input register and the result register.
// Stalls: when m_tready is low the result is held and the input register
//   keeps one more item; s_tready drops only when both are full.
// Reset: rst_n clears the pipeline, returns the master to idle, clears
//   read_data and no_presence and restores the register defaults.
module onewire_bus_master_unit
    import owm_pkg::*;
#(
    parameter int TIMER_BITS = 10
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // bus_level[0], cmd_data[8:1], zero pad
    input  logic [S_TUSER_W-1:0] s_tuser,  // cmd_valid[0], func[2:1]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // drive_low[0], busy_res[1], done_res[2],
                                           // read_data[10:3], no_presence[11], zero pad
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    output logic [APB_DW-1:0]    prdata,
    output logic                 pready
);

    cfg_t  cfg;
    item_t in_item_reg;
    logic  in_valid_reg;
    res_t  res;
    res_t  out_res_reg;
    logic  out_valid_reg;
    logic  out_free;
    logic  step;

    owm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // the tick is processed when the result register can take its output
    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || step;

    owm_core #(
        .TIMER_BITS (TIMER_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_item_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.bus_level <= s_tdata[0];
            in_item_reg.cmd_data  <= s_tdata[8:1];
            in_item_reg.cmd_valid <= s_tuser[0];
            in_item_reg.func      <= s_tuser[2:1];
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_TDATA_W'({out_res_reg.no_presence, out_res_reg.read_data,
                                  out_res_reg.done_res, out_res_reg.busy_res,
                                  out_res_reg.drive_low});

    // input side only backs up behind a stalled result
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("input stalled without output back-pressure");

    // a processed tick always shows up as a result next cycle
    a_step_out: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> m_tvalid)
        else $error("processed tick produced no result");

    // a done pulse never comes with busy set
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.done_res |-> !res.busy_res)
        else $error("done pulse while still busy");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Testbench for the 1-Wire bus master. One stream item is one bus tick and
// gives exactly one result item, so every accepted input item queues one
// predicted result and every accepted output item is checked against the
// oldest one. Timing registers are only touched with the master idle and
// the pipeline empty.
module tb;

    import owm_pkg::*;

    // code 3 on func is no command at all
    localparam logic [1:0] FUNC_NONE = 2'd3;

    // a run is some 500 items; even at the worst stall pattern that stays well
    // under the limit
    localparam int unsigned CYCLE_LIMIT = 50_000;

    // how the sampled line level is chosen for the ticks of a command
    typedef enum logic [1:0] {
        LV_LOW,
        LV_HIGH,
        LV_RAND
    } lvl_t;

    // receiver behaviour, chosen anew at random
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_CHOKE
    } rx_mode_t;

    // phases of the master, mirrored by the predictor
    typedef enum logic [3:0] {
        S_IDLE,
        S_RST_LOW,
        S_RST_WAIT,
        S_RST_TAIL,
        S_W1_LOW,
        S_W1_REL,
        S_W0_LOW,
        S_W0_GAP,
        S_RD_LOW,
        S_RD_REL
    } bus_ph_t;

    // clock and DUT ports; every input known from time zero
    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic [S_TUSER_W-1:0] s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b1;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [APB_AW-1:0]    paddr    = '0;
    logic [APB_DW-1:0]    pwdata   = '0;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    // predictor state: timing registers and the master's own state
    logic [CFG_W-1:0] cfg_m [8];
    bus_ph_t          bus_ph;
    logic [CFG_W-1:0] ph_left;
    logic [2:0]       bit_pos;
    logic [7:0]       byte_sr;
    logic             no_pres;
    logic [1:0]       cur_func;
    logic [7:0]       last_rd;
    logic             rd_sample_due;
    logic             done_pulse;

    res_t        tick_out_q [$];   // predicted result items, oldest first
    int unsigned ticks_sent = 0;   // input items accepted
    int unsigned cmds_done  = 0;   // commands finished, by the predictor
    int unsigned res_seen   = 0;
    int unsigned n_err      = 0;
    int unsigned cycle_cnt  = 0;
    int unsigned burst_left = 0;

    rx_mode_t    rdy_mode   = RX_OPEN;
    int unsigned rdy_left   = 0;
    int unsigned rdy_cnt    = 0;
    int unsigned rdy_period = 2;

    onewire_bus_master_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // 4 ns period
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    // ---------------------------------------------------------------------
    // Predictor
    // ---------------------------------------------------------------------

    function automatic void master_reset();
        cfg_m[REG_RESET_LOW]      = RST_RESET_LOW;
        cfg_m[REG_PRESENCE_WAIT]  = RST_PRESENCE_WAIT;
        cfg_m[REG_PRESENCE_TAIL]  = RST_PRESENCE_TAIL;
        cfg_m[REG_WRITE_ONE_LOW]  = RST_WRITE_ONE_LOW;
        cfg_m[REG_WRITE_ZERO_LOW] = RST_WRITE_ZERO_LOW;
        cfg_m[REG_SLOT_RELEASE]   = RST_SLOT_RELEASE;
        cfg_m[REG_READ_LOW]       = RST_READ_LOW;
        cfg_m[REG_WRITE_ZERO_GAP] = RST_WRITE_ZERO_GAP;
        bus_ph        = S_IDLE;
        ph_left       = '0;
        bit_pos       = '0;
        byte_sr       = '0;
        no_pres       = 1'b0;
        cur_func      = FUNC_RESET;
        last_rd       = '0;
        rd_sample_due = 1'b0;
        done_pulse    = 1'b0;
    endfunction

    // length of a phase; 0 means one tick, except where the phase may be empty
    function automatic logic [CFG_W-1:0] phase_ticks(input reg_idx_t idx, input bit zero_ok);
        logic [CFG_W-1:0] v;
        v = cfg_m[idx];
        if (v == '0 && !zero_ok)
            v = CFG_W'(1);
        return v;
    endfunction

    function automatic bit count_down();
        if (ph_left != '0)
            ph_left = ph_left - CFG_W'(1);
        return ph_left == '0;
    endfunction

    function automatic void end_command();
        bus_ph     = S_IDLE;
        ph_left    = '0;
        done_pulse = 1'b1;
        if (cur_func == FUNC_READ)
            last_rd = byte_sr;
        cmds_done++;
    endfunction

    function automatic void open_slot();
        if (cur_func == FUNC_WRITE)
        begin
            if (byte_sr[bit_pos])
            begin
                bus_ph  = S_W1_LOW;
                ph_left = phase_ticks(REG_WRITE_ONE_LOW, 1'b0);
            end
            else
            begin
                bus_ph  = S_W0_LOW;
                ph_left = phase_ticks(REG_WRITE_ZERO_LOW, 1'b0);
            end
        end
        else
        begin
            bus_ph  = S_RD_LOW;
            ph_left = phase_ticks(REG_READ_LOW, 1'b0);
        end
    endfunction

    function automatic void advance_bit();
        if (bit_pos == 3'd7)
            end_command();
        else
        begin
            bit_pos = bit_pos + 3'd1;
            open_slot();
        end
    endfunction

    // one bus tick: updates the mirrored state, returns the result item
    function automatic res_t master_tick(input item_t it);
        res_t             r;
        logic             drv;
        logic [CFG_W-1:0] tail;
        drv        = 1'b0;
        done_pulse = 1'b0;

        // the tick that takes a command is the first tick of its first phase
        if (bus_ph == S_IDLE && it.cmd_valid && it.func != FUNC_NONE)
        begin
            cur_func      = it.func;
            bit_pos       = '0;
            rd_sample_due = 1'b0;
            if (it.func == FUNC_RESET)
            begin
                bus_ph  = S_RST_LOW;
                ph_left = phase_ticks(REG_RESET_LOW, 1'b0);
            end
            else
            begin
                byte_sr = (it.func == FUNC_WRITE) ? it.cmd_data : 8'h00;
                open_slot();
            end
        end

        case (bus_ph)
            S_RST_LOW:
            begin
                drv = 1'b1;
                if (count_down())
                begin
                    bus_ph  = S_RST_WAIT;
                    ph_left = phase_ticks(REG_PRESENCE_WAIT, 1'b0);
                end
            end
            S_RST_WAIT:
            begin
                if (count_down())
                begin
                    // presence sampled on the last tick of the wait
                    no_pres = it.bus_level;
                    tail    = phase_ticks(REG_PRESENCE_TAIL, 1'b1);
                    if (tail == '0)
                        end_command();
                    else
                    begin
                        bus_ph  = S_RST_TAIL;
                        ph_left = tail;
                    end
                end
            end
            S_RST_TAIL:
            begin
                if (count_down())
                    end_command();
            end
            S_W1_LOW:
            begin
                drv = 1'b1;
                if (count_down())
                begin
                    bus_ph  = S_W1_REL;
                    ph_left = phase_ticks(REG_SLOT_RELEASE, 1'b0);
                end
            end
            S_W0_LOW:
            begin
                drv = 1'b1;
                if (count_down())
                begin
                    bus_ph  = S_W0_GAP;
                    ph_left = phase_ticks(REG_WRITE_ZERO_GAP, 1'b0);
                end
            end
            S_W1_REL, S_W0_GAP:
            begin
                if (count_down())
                    advance_bit();
            end
            S_RD_LOW:
            begin
                drv = 1'b1;
                if (count_down())
                begin
                    bus_ph        = S_RD_REL;
                    ph_left       = phase_ticks(REG_SLOT_RELEASE, 1'b0);
                    rd_sample_due = 1'b1;
                end
            end
            S_RD_REL:
            begin
                // read bit taken on the first released tick
                if (rd_sample_due)
                begin
                    if (it.bus_level)
                        byte_sr[bit_pos] = 1'b1;
                    rd_sample_due = 1'b0;
                end
                if (count_down())
                    advance_bit();
            end
            default:
                bus_ph = S_IDLE;
        endcase

        r.drive_low   = drv;
        r.busy_res    = (bus_ph != S_IDLE);
        r.done_res    = done_pulse;
        r.read_data   = last_rd;
        r.no_presence = no_pres;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------

    task automatic report_err(input string what, input logic [31:0] want, input logic [31:0] got);
        // keep the log short on a badly broken build, but count everything
        if (n_err < 40)
            $display("mismatch at result %0d: %s want %0h got %0h", res_seen, what, want, got);
        n_err++;
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] d);
        res_t want;
        if (tick_out_q.size() == 0)
        begin
            report_err("result with nothing pending", 32'd0, 32'(d));
            return;
        end
        want = tick_out_q.pop_front();
        if (d[0] !== want.drive_low)
            report_err("drive_low", 32'(want.drive_low), 32'(d[0]));
        if (d[1] !== want.busy_res)
            report_err("busy_res", 32'(want.busy_res), 32'(d[1]));
        if (d[2] !== want.done_res)
            report_err("done_res", 32'(want.done_res), 32'(d[2]));
        if (d[10:3] !== want.read_data)
            report_err("read_data", 32'(want.read_data), 32'(d[10:3]));
        if (d[11] !== want.no_presence)
            report_err("no_presence", 32'(want.no_presence), 32'(d[11]));
        res_seen++;
    endtask

    // Both handshakes sampled at the rising edge. The output side is checked
    // first so that a result can never be matched with the item taken at the
    // same edge.
    always @(posedge clk)
    begin : mon
        item_t seen;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready)
            begin
                seen.bus_level = s_tdata[0];
                seen.cmd_data  = s_tdata[8:1];
                seen.cmd_valid = s_tuser[0];
                seen.func      = s_tuser[2:1];
                tick_out_q.push_back(master_tick(seen));
                ticks_sent++;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stalls on a pattern of its own
    // ---------------------------------------------------------------------

    always @(negedge clk)
    begin
        if (rdy_left == 0)
        begin
            rdy_mode   = rx_mode_t'($urandom_range(0, 3));
            rdy_left   = $urandom_range(16, 200);
            rdy_period = $urandom_range(2, 5);
        end
        rdy_left--;
        rdy_cnt++;
        case (rdy_mode)
            RX_OPEN:     m_tready <= 1'b1;
            RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: m_tready <= (rdy_cnt % rdy_period) != 0;
            default:     m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers. Tasks that drive the input side start and end at a
    // falling edge at which nothing has been driven yet.
    // ---------------------------------------------------------------------

    // plain tick, no command; func and data carry junk
    function automatic item_t make_tick(input lvl_t lv);
        item_t it;
        case (lv)
            LV_LOW:  it.bus_level = 1'b0;
            LV_HIGH: it.bus_level = 1'b1;
            default: it.bus_level = 1'($urandom_range(0, 1));
        endcase
        it.cmd_valid = 1'b0;
        it.func      = 2'($urandom_range(0, 3));
        it.cmd_data  = 8'($urandom_range(0, 255));
        return it;
    endfunction

    // tick offered at idle that must not start anything
    function automatic item_t idle_noise();
        item_t it;
        it           = make_tick(LV_RAND);
        it.cmd_valid = 1'($urandom_range(0, 1));
        if (it.cmd_valid)
            it.func = FUNC_NONE;
        return it;
    endfunction

    // sends one item in bursts with random gaps between them
    task automatic send_tick(input item_t it);
        int unsigned gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 20)
                                                     : $urandom_range(1, 4);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            repeat (gap)
            begin
                s_tvalid <= 1'b0;
                @(negedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-9){1'b0}}, it.cmd_data, it.bus_level};
        s_tuser  <= {it.func, it.cmd_valid};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    // offers a command at idle, then ticks until the master is idle again;
    // some of those ticks offer commands that must be ignored
    task automatic run_cmd(input logic [1:0] fn, input logic [7:0] data, input lvl_t lv);
        item_t it;
        it           = make_tick(lv);
        it.cmd_valid = 1'b1;
        it.func      = fn;
        it.cmd_data  = data;
        send_tick(it);
        while (bus_ph != S_IDLE)
        begin
            it = make_tick(lv);
            if ($urandom_range(0, 3) == 0)
                it.cmd_valid = 1'b1;
            send_tick(it);
        end
    endtask

    // master idle, every result in, pipeline empty
    task automatic wait_idle();
        while (bus_ph != S_IDLE)
            send_tick(make_tick(LV_RAND));
        s_tvalid <= 1'b0;
        while (tick_out_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // APB write: setup, access, register taken at the edge with pready high
    task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {{(APB_DW-CFG_W){1'b0}}, val};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        cfg_m[idx] = val;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // APB read: setup, access, data taken at the edge with pready high
    task automatic read_reg(input reg_idx_t idx, output logic [APB_DW-1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        val = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
    endtask

    task automatic cfg_all(input logic [CFG_W-1:0] val);
        for (int i = 0; i < 8; i++)
            write_reg(reg_idx_t'(i), val);
    endtask

    // short phases so that a whole command costs a few dozen items
    task automatic cfg_short();
        write_reg(REG_RESET_LOW,      10'd4);
        write_reg(REG_PRESENCE_WAIT,  10'd3);
        write_reg(REG_PRESENCE_TAIL,  10'd3);
        write_reg(REG_WRITE_ONE_LOW,  10'd1);
        write_reg(REG_WRITE_ZERO_LOW, 10'd3);
        write_reg(REG_SLOT_RELEASE,   10'd2);
        write_reg(REG_READ_LOW,       10'd2);
        write_reg(REG_WRITE_ZERO_GAP, 10'd1);
    endtask

    // short phases mostly, now and then a zero or a longer one
    task automatic cfg_random();
        int unsigned r;
        for (int i = 0; i < 8; i++)
        begin
            r = $urandom_range(0, 19);
            if (r == 0)
                write_reg(reg_idx_t'(i), '0);
            else if (r < 17)
                write_reg(reg_idx_t'(i), CFG_W'($urandom_range(1, 4)));
            else
                write_reg(reg_idx_t'(i), CFG_W'($urandom_range(5, 16)));
        end
    endtask

    // ---------------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------------

    // timing registers read back their reset values
    task automatic test_reg_defaults();
        logic [APB_DW-1:0] v;
        for (int i = 0; i < 8; i++)
        begin
            read_reg(reg_idx_t'(i), v);
            if (v !== APB_DW'(cfg_m[i]))
                report_err("register default", 32'(cfg_m[i]), 32'(v));
        end
    endtask

    // reset pulse: presence seen, then not seen
    task automatic test_reset_presence();
        run_cmd(FUNC_RESET, 8'($urandom_range(0, 255)), LV_LOW);
        run_cmd(FUNC_RESET, 8'($urandom_range(0, 255)), LV_HIGH);
    endtask

    // byte extremes out, all-ones, all-zeros and mixed bytes in
    task automatic test_write_read();
        run_cmd(FUNC_WRITE, 8'h00, LV_RAND);
        run_cmd(FUNC_WRITE, 8'hFF, LV_RAND);
        run_cmd(FUNC_WRITE, 8'hA5, LV_RAND);
        run_cmd(FUNC_READ, 8'h00, LV_HIGH);
        run_cmd(FUNC_READ, 8'hFF, LV_LOW);
        run_cmd(FUNC_READ, 8'($urandom_range(0, 255)), LV_RAND);
    endtask

    // code 3 and unflagged commands at idle leave the master alone
    task automatic test_ignored_cmds();
        item_t it;
        run_cmd(FUNC_NONE, 8'($urandom_range(0, 255)), LV_RAND);
        it           = make_tick(LV_RAND);
        it.func      = FUNC_READ;
        send_tick(it);
        it.func      = FUNC_RESET;
        send_tick(it);
        repeat (6) send_tick(idle_noise());
        wait_idle();
    endtask

    // zero-valued registers: one tick each, empty presence tail
    task automatic test_zero_lengths();
        cfg_all('0);
        run_cmd(FUNC_RESET, 8'h00, LV_LOW);
        run_cmd(FUNC_RESET, 8'h00, LV_HIGH);
        run_cmd(FUNC_WRITE, 8'h3C, LV_RAND);
        run_cmd(FUNC_READ, 8'h00, LV_RAND);
        wait_idle();
        write_reg(REG_PRESENCE_TAIL, 10'd1);
        run_cmd(FUNC_RESET, 8'h00, LV_RAND);
        wait_idle();
    endtask

    // reset phases a few dozen ticks long
    task automatic test_long_phases();
        cfg_short();
        write_reg(REG_RESET_LOW,     10'd24);
        write_reg(REG_PRESENCE_WAIT, 10'd16);
        write_reg(REG_PRESENCE_TAIL, 10'd20);
        run_cmd(FUNC_RESET, 8'h00, LV_RAND);
        wait_idle();
    endtask

    // random command streams over several short timing settings
    task automatic test_random();
        int unsigned t0;
        int unsigned c0;
        int unsigned n_cmd;
        t0    = ticks_sent;
        c0    = cmds_done;
        n_cmd = 0;
        while (ticks_sent - t0 < 120 || cmds_done - c0 < 6)
        begin
            if (n_cmd % 8 == 0)
            begin
                wait_idle();
                cfg_random();
            end
            n_cmd++;
            if ($urandom_range(0, 9) < 8)
                run_cmd(2'($urandom_range(0, 2)), 8'($urandom_range(0, 255)), LV_RAND);
            else
                repeat ($urandom_range(1, 5)) send_tick(idle_noise());
        end
        wait_idle();
    endtask

    // watchdog on the cycle counter
    initial
    begin
        wait (cycle_cnt >= CYCLE_LIMIT);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        master_reset();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reg_defaults();
        cfg_short();
        test_reset_presence();
        test_write_read();
        test_ignored_cmds();
        test_zero_lengths();
        test_long_phases();
        test_random();

        // last results are in; give the pipeline time to show any stray item
        wait_idle();
        repeat (8) @(negedge clk);
        if (tick_out_q.size() != 0)
            report_err("results never arrived", 32'(tick_out_q.size()), 32'd0);

        if (n_err == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
